@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every rising edge outside reset
`define CLRT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// cond must never be seen at a rising edge outside reset
`define CLRT_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `CLRT_ASSERT(label, clk, rst, !(cond), msg)

`endif

@@ design/clrt_pkg.sv @@
// ----------------------------------------------------------------------------
// CPU load ratio tracker package
// Widths, constants, state encoding and status structs shared by the block.
// ----------------------------------------------------------------------------
package clrt_pkg;

   localparam int CNT_W        = 64;                // running tick counters
   localparam int TPI_W        = 32;                // ticks per interval register
   localparam int LIMIT_W      = TPI_W + 4;         // ten times ticks per interval
   localparam int LOAD_W       = 20;                // load field
   localparam int DIGIT_W      = 8;                 // serial digit of the delta unit
   localparam int NUM_DIGITS   = CNT_W / DIGIT_W;
   localparam int DIGIT_CNT_W  = $clog2(NUM_DIGITS);
   localparam int QCNT_W       = $clog2(LOAD_W);
   localparam int REQ_DATA_W   = 2 * CNT_W;
   localparam int RSP_DATA_W   = ((LOAD_W + 7) / 8) * 8;
   localparam int RSP_USER_W   = 2;
   localparam int JUMP_FACTOR  = 10;
   localparam int FRACTION_BITS_DEFAULT = 16;

   localparam logic [TPI_W-1:0]  TPI_RESET = TPI_W'(100);
   localparam logic [LOAD_W-1:0] LOAD_MAX  = {LOAD_W{1'b1}};

   // response tuser bit positions
   localparam int USER_REJECTED = 0;
   localparam int USER_UPDATED  = 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DELTA,
      ST_CHECK,
      ST_DIVIDE,
      ST_REPLY
   } clrt_state_type;

   typedef struct packed {
      logic done;        // last digit step in this cycle
      logic total_neg;   // total counter went backwards
      logic busy_neg;    // busy counter went backwards
      logic too_big;     // total delta above the jump limit
   } clrt_delta_stat_type;

   typedef struct packed {
      logic done;        // last quotient step in this cycle
      logic saturated;   // ratio does not fit the load field
   } clrt_div_stat_type;

   function automatic logic [LIMIT_W-1:0] jump_limit(input logic [TPI_W-1:0] tpi);
      jump_limit = LIMIT_W'(tpi) * LIMIT_W'(JUMP_FACTOR);
   endfunction

endpackage

@@ design/clrt_delta.sv @@
// ----------------------------------------------------------------------------
// Digit-serial delta unit
// Subtracts the previous sample from the new one a digit per cycle, LSB first,
// and compares the total delta with the jump limit on the same digits.
// ----------------------------------------------------------------------------
module clrt_delta
   import clrt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [CNT_W-1:0]          total,
   input  logic [CNT_W-1:0]          busy,
   input  logic [CNT_W-1:0]          prev_total,
   input  logic [CNT_W-1:0]          prev_busy,
   input  logic [LIMIT_W-1:0]        limit,
   output logic [CNT_W-1:0]          total_delta,
   output logic [CNT_W-1:0]          busy_delta,
   output clrt_delta_stat_type       stat
);

   logic [CNT_W-1:0]       t_ff, t_in, pt_ff, pt_in;
   logic [CNT_W-1:0]       b_ff, b_in, pb_ff, pb_in;
   logic [CNT_W-1:0]       lim_ff, lim_in;
   logic                   bt_ff, bt_in, bb_ff, bb_in, bc_ff, bc_in;
   logic [DIGIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   run_ff, run_in;
   logic [DIGIT_W:0]       dt, db, dc;
   logic                   last_step;

   assign dt = {1'b0, t_ff[DIGIT_W-1:0]} - {1'b0, pt_ff[DIGIT_W-1:0]}
               - (DIGIT_W+1)'(bt_ff);
   assign db = {1'b0, b_ff[DIGIT_W-1:0]} - {1'b0, pb_ff[DIGIT_W-1:0]}
               - (DIGIT_W+1)'(bb_ff);
   // limit minus delta: a final borrow means the delta is above the limit
   assign dc = {1'b0, lim_ff[DIGIT_W-1:0]} - {1'b0, dt[DIGIT_W-1:0]}
               - (DIGIT_W+1)'(bc_ff);

   assign last_step = run_ff && (cnt_ff == DIGIT_CNT_W'(NUM_DIGITS - 1));

   always_comb begin
      t_in   = t_ff;
      pt_in  = pt_ff;
      b_in   = b_ff;
      pb_in  = pb_ff;
      lim_in = lim_ff;
      bt_in  = bt_ff;
      bb_in  = bb_ff;
      bc_in  = bc_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (start) begin
         t_in   = total;
         pt_in  = prev_total;
         b_in   = busy;
         pb_in  = prev_busy;
         lim_in = CNT_W'(limit);
         bt_in  = 1'b0;
         bb_in  = 1'b0;
         bc_in  = 1'b0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // shift the difference digits in from the top
         t_in   = {dt[DIGIT_W-1:0], t_ff[CNT_W-1:DIGIT_W]};
         b_in   = {db[DIGIT_W-1:0], b_ff[CNT_W-1:DIGIT_W]};
         pt_in  = {{DIGIT_W{1'b0}}, pt_ff[CNT_W-1:DIGIT_W]};
         pb_in  = {{DIGIT_W{1'b0}}, pb_ff[CNT_W-1:DIGIT_W]};
         lim_in = {{DIGIT_W{1'b0}}, lim_ff[CNT_W-1:DIGIT_W]};
         bt_in  = dt[DIGIT_W];
         bb_in  = db[DIGIT_W];
         bc_in  = dc[DIGIT_W];
         cnt_in = cnt_ff + 1'b1;
         if (last_step) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff   <= t_in;
      pt_ff  <= pt_in;
      b_ff   <= b_in;
      pb_ff  <= pb_in;
      lim_ff <= lim_in;
      bt_ff  <= bt_in;
      bb_ff  <= bb_in;
      bc_ff  <= bc_in;
   end

   assign total_delta    = t_ff;
   assign busy_delta     = b_ff;
   assign stat.done      = last_step;
   assign stat.total_neg = bt_ff;
   assign stat.busy_neg  = bb_ff;
   assign stat.too_big   = bc_ff;

endmodule

@@ design/clrt_divider.sv @@
// ----------------------------------------------------------------------------
// Load ratio divider
// Restoring divider giving one quotient bit per cycle for
// (dividend << FRACTION_BITS) / divisor, saturated at the load maximum.
// ----------------------------------------------------------------------------
module clrt_divider
   import clrt_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [CNT_W-1:0]     dividend,
   input  logic [LIMIT_W-1:0]   divisor,
   output logic [LOAD_W-1:0]    quotient,
   output clrt_div_stat_type    stat
);

   localparam int N_W   = CNT_W + FRACTION_BITS;
   localparam int HI_W  = N_W - LOAD_W;
   localparam int REM_W = LIMIT_W + 1;

   logic [N_W-1:0]     num;
   logic [HI_W-1:0]    num_hi;
   logic [REM_W-1:0]   trial;
   logic [REM_W:0]     trial_diff;
   logic               fits;
   logic               last_step;

   logic [LIMIT_W-1:0] rem_ff, rem_in;
   logic [LOAD_W-1:0]  lo_ff, lo_in;
   logic [LOAD_W-1:0]  q_ff, q_in;
   logic               sat_ff, sat_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               run_ff, run_in;

   assign num    = {dividend, {FRACTION_BITS{1'b0}}};
   assign num_hi = num[N_W-1:LOAD_W];

   assign trial      = {rem_ff, lo_ff[LOAD_W-1]};
   assign trial_diff = {1'b0, trial} - {2'b00, divisor};
   assign fits       = !trial_diff[REM_W];
   assign last_step  = run_ff && (cnt_ff == QCNT_W'(LOAD_W - 1));

   always_comb begin
      rem_in = rem_ff;
      lo_in  = lo_ff;
      q_in   = q_ff;
      sat_in = sat_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (start) begin
         // quotient reaches 2^LOAD_W exactly when the high part is not below the divisor
         sat_in = (num_hi >= HI_W'(divisor));
         rem_in = num_hi[LIMIT_W-1:0];
         lo_in  = num[LOAD_W-1:0];
         q_in   = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? trial_diff[LIMIT_W-1:0] : trial[LIMIT_W-1:0];
         lo_in  = {lo_ff[LOAD_W-2:0], 1'b0};
         q_in   = {q_ff[LOAD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (last_step) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
      sat_ff <= sat_in;
   end

   assign quotient       = sat_ff ? LOAD_MAX : q_ff;
   assign stat.done      = last_step;
   assign stat.saturated = sat_ff;

endmodule

@@ design/cpu_load_ratio_tracker_top.sv @@
// Sequence: an accepted request goes through the 8-bit digit-serial delta unit,
// the check state and, unless the sample is rejected or the total delta is zero,
// the one-bit-per-cycle divider; the reply state then registers the response
// once the output is free. No new request is taken until then.
// Reset (synchronous, active high): previous sample and load clear to zero,
// the interval setting returns to 100, no response pending.
// ----------------------------------------------------------------------------
// CPU load ratio tracker
// Tracks busy/total tick counters and reports the load ratio in fixed point.
// ----------------------------------------------------------------------------
module cpu_load_ratio_tracker_top
   import clrt_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [63:0] total_ticks, [127:64] busy_ticks
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [19:0] load, [23:20] zero
   output logic [RSP_USER_W-1:0]  rsp_tuser,   // [0] sample_rejected, [1] load_updated
   // configuration
   input  logic                   csr_wr_en,
   input  logic [TPI_W-1:0]       csr_wr_data
);

   clrt_state_type      state_ff, state_in;
   logic [TPI_W-1:0]    tpi_ff, tpi_in;
   logic [CNT_W-1:0]    prev_total_ff, prev_total_in;
   logic [CNT_W-1:0]    prev_busy_ff, prev_busy_in;
   logic [LOAD_W-1:0]   last_load_ff, last_load_in;
   logic                rej_ff, rej_in;
   logic                upd_ff, upd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LOAD_W-1:0]   rsp_load_ff, rsp_load_in;
   logic                rsp_rej_ff, rsp_rej_in;
   logic                rsp_upd_ff, rsp_upd_in;

   logic [CNT_W-1:0]    req_total, req_busy;
   logic [CNT_W-1:0]    total_delta, busy_delta;
   logic [LOAD_W-1:0]   quotient;
   clrt_delta_stat_type dstat;
   clrt_div_stat_type   qstat;
   logic                accept;
   logic                out_free;
   logic                reject;
   logic                zero_delta;
   logic                div_start;
   logic [LOAD_W-1:0]   new_load;

   assign req_total = req_tdata[CNT_W-1:0];
   assign req_busy  = req_tdata[2*CNT_W-1:CNT_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   clrt_delta u_delta (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .total       (req_total),
      .busy        (req_busy),
      .prev_total  (prev_total_ff),
      .prev_busy   (prev_busy_ff),
      .limit       (jump_limit(tpi_ff)),
      .total_delta (total_delta),
      .busy_delta  (busy_delta),
      .stat        (dstat)
   );

   // divisor does not exceed the jump limit whenever the divider runs
   clrt_divider #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (busy_delta),
      .divisor  (total_delta[LIMIT_W-1:0]),
      .quotient (quotient),
      .stat     (qstat)
   );

   assign reject     = dstat.total_neg || dstat.busy_neg || dstat.too_big;
   assign zero_delta = (total_delta == '0);
   assign div_start  = (state_ff == ST_CHECK) && !reject && !zero_delta;
   assign new_load   = upd_ff ? quotient : last_load_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept)     state_in = ST_DELTA;
         ST_DELTA:  if (dstat.done) state_in = ST_CHECK;
         ST_CHECK:  state_in = div_start ? ST_DIVIDE : ST_REPLY;
         ST_DIVIDE: if (qstat.done) state_in = ST_REPLY;
         ST_REPLY:  if (out_free)   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and response register
   always_comb begin
      tpi_in        = csr_wr_en ? csr_wr_data : tpi_ff;
      prev_total_in = prev_total_ff;
      prev_busy_in  = prev_busy_ff;
      last_load_in  = last_load_ff;
      rej_in        = rej_ff;
      upd_in        = upd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_load_in   = rsp_load_ff;
      rsp_rej_in    = rsp_rej_ff;
      rsp_upd_in    = rsp_upd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // the new sample always replaces the previous one
            if (accept) begin
               prev_total_in = req_total;
               prev_busy_in  = req_busy;
            end
         end
         ST_CHECK: begin
            rej_in = reject;
            upd_in = !reject && !zero_delta;
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_load_in  = new_load;
               rsp_rej_in   = rej_ff;
               rsp_upd_in   = upd_ff;
               last_load_in = new_load;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tpi_ff        <= TPI_RESET;
         prev_total_ff <= '0;
         prev_busy_ff  <= '0;
         last_load_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tpi_ff        <= tpi_in;
         prev_total_ff <= prev_total_in;
         prev_busy_ff  <= prev_busy_in;
         last_load_ff  <= last_load_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rej_ff      <= rej_in;
      upd_ff      <= upd_in;
      rsp_load_ff <= rsp_load_in;
      rsp_rej_ff  <= rsp_rej_in;
      rsp_upd_ff  <= rsp_upd_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_load_ff);
   always_comb begin
      rsp_tuser                = '0;
      rsp_tuser[USER_REJECTED] = rsp_rej_ff;
      rsp_tuser[USER_UPDATED]  = rsp_upd_ff;
   end

endmodule

@@ design/clrt_checker.sv @@
// ----------------------------------------------------------------------------
// CPU load ratio tracker checker
// Port-level assertions on the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clrt_checker
   import clrt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [RSP_USER_W-1:0]  rsp_tuser
);

   logic [LOAD_W-1:0] seen_load_ff, seen_load_in;

   // track the load of the last delivered response
   assign seen_load_in = (rsp_tvalid && rsp_tready) ? rsp_tdata[LOAD_W-1:0] : seen_load_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_load_ff <= '0;
      end else begin
         seen_load_ff <= seen_load_in;
      end
   end

   `CLRT_ASSERT_NEVER(a_rej_and_upd, clock, reset, rsp_tvalid && rsp_tuser[USER_REJECTED] && rsp_tuser[USER_UPDATED], "response both rejected and updated")

   `CLRT_ASSERT(a_load_held, clock, reset, rsp_tvalid && !rsp_tuser[USER_UPDATED] |-> rsp_tdata[LOAD_W-1:0] == seen_load_ff, "load changed without an update")

   `CLRT_ASSERT(a_one_request, clock, reset, req_tvalid && req_tready |=> !req_tready, "second request taken while busy")

   `CLRT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")

endmodule

bind cpu_load_ratio_tracker_top clrt_checker u_clrt_checker (.*);
